FILE: src/rke_pkg.sv
// Shared types, constants and lookup tables for the Rijndael key expansion block.
// Used by every module under src; depends on nothing else.
package rke_pkg;

  localparam int KEY_COL_SLOTS      = 8;
  localparam int SBOX_SPLIT_COLUMNS = 6;
  localparam int MIN_COLUMNS        = 4;
  localparam int MIN_ROUNDS         = 1;

  localparam logic [1:0] REG_KEY_COLUMNS   = 2'd0;
  localparam logic [1:0] REG_BLOCK_COLUMNS = 2'd1;
  localparam logic [1:0] REG_ROUND_COUNT   = 2'd2;

  localparam logic [3:0] KEY_COLUMNS_RESET   = 4'd4;
  localparam logic [3:0] BLOCK_COLUMNS_RESET = 4'd4;
  localparam logic [3:0] ROUND_COUNT_RESET   = 4'd10;

  typedef logic [31:0] column_t;

  typedef struct packed {
    logic [63:0] key_a;
    logic [63:0] key_b;
    logic [63:0] key_c;
    logic [63:0] key_d;
    logic [2:0]  kc_last;
    logic [2:0]  bc_last;
    logic [3:0]  rounds;
  } job_t;

  typedef struct packed {
    logic [3:0]  round_index;
    logic [63:0] key_a;
    logic [63:0] key_b;
    logic [63:0] key_c;
    logic [63:0] key_d;
    logic        last;
  } result_t;

  typedef enum logic {
    ENG_IDLE,
    ENG_RUN
  } eng_state_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // Round constants; the first expansion step uses entry one.
  localparam logic [7:0] RCON [32] = '{
    8'h00,8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36,8'h6c,8'hd8,8'hab,8'h4d,8'h9a,
    8'h2f,8'h5e,8'hbc,8'h63,8'hc6,8'h97,8'h35,8'h6a,8'hd4,8'hb3,8'h7d,8'hfa,8'hef,8'hc5,8'h91,8'h39
  };

  function automatic column_t sub_word(input column_t w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

endpackage

FILE: src/rke_front.sv
// Front end: accepts cipher keys, clamps the configuration into range and
// queues one job per key for the expansion engine. Depends on rke_pkg.
module rke_front #(
  parameter int MAX_KEY_COLUMNS   = 8,
  parameter int MAX_BLOCK_COLUMNS = 8,
  parameter int MAX_ROUNDS        = 14
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  logic [63:0]   key_word_a,
  input  logic [63:0]   key_word_b,
  input  logic [63:0]   key_word_c,
  input  logic [63:0]   key_word_d,
  input  logic [3:0]    key_columns,
  input  logic [3:0]    block_columns,
  input  logic [3:0]    round_count,
  output logic          job_valid,
  output rke_pkg::job_t job,
  input  logic          job_take
);

  rke_pkg::job_t queue [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  logic          accept;
  logic [3:0]    kc;
  logic [3:0]    bc;
  logic [3:0]    rc;
  rke_pkg::job_t new_job;

  always_comb begin
    kc = key_columns;
    if (key_columns < 4'(rke_pkg::MIN_COLUMNS)) begin
      kc = 4'(rke_pkg::MIN_COLUMNS);
    end else if (key_columns > 4'(MAX_KEY_COLUMNS)) begin
      kc = 4'(MAX_KEY_COLUMNS);
    end
    bc = block_columns;
    if (block_columns < 4'(rke_pkg::MIN_COLUMNS)) begin
      bc = 4'(rke_pkg::MIN_COLUMNS);
    end else if (block_columns > 4'(MAX_BLOCK_COLUMNS)) begin
      bc = 4'(MAX_BLOCK_COLUMNS);
    end
    rc = round_count;
    if (round_count < 4'(rke_pkg::MIN_ROUNDS)) begin
      rc = 4'(rke_pkg::MIN_ROUNDS);
    end else if (round_count > 4'(MAX_ROUNDS)) begin
      rc = 4'(MAX_ROUNDS);
    end
  end

  always_comb begin
    new_job.key_a   = key_word_a;
    new_job.key_b   = key_word_b;
    new_job.key_c   = key_word_c;
    new_job.key_d   = key_word_d;
    new_job.kc_last = 3'(kc - 4'd1);
    new_job.bc_last = 3'(bc - 4'd1);
    new_job.rounds  = rc;
  end

  assign full      = (count == 2'd2);
  assign accept    = push && !full;
  assign job_valid = (count != 2'd0);
  assign job       = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (accept) begin
      queue[wr_ptr] <= new_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (accept) begin
        wr_ptr <= ~wr_ptr;
      end
      if (job_take) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(accept) - 2'(job_take);
    end
  end

endmodule

FILE: src/rke_engine.sv
// Back end: expands one queued key into round keys, one key column per cycle while the
// result queue has room, through a shift line of the last eight columns and one shared
// S-box word. Depends on rke_pkg.
module rke_engine (
  input  logic             clk,
  input  logic             rst,
  input  logic             job_valid,
  input  rke_pkg::job_t    job,
  output logic             job_take,
  input  logic             res_full,
  output logic             res_push,
  output rke_pkg::result_t res_item,
  output logic             busy
);

  rke_pkg::eng_state_t state;
  rke_pkg::eng_state_t state_next;

  rke_pkg::column_t sreg [rke_pkg::KEY_COL_SLOTS];
  rke_pkg::column_t rbuf [rke_pkg::KEY_COL_SLOTS];
  rke_pkg::column_t key_col [rke_pkg::KEY_COL_SLOTS];
  rke_pkg::column_t col_out [rke_pkg::KEY_COL_SLOTS];

  logic [2:0] col_idx;
  logic       first;
  logic [4:0] rptr;
  logic [2:0] pos;
  logic [3:0] rnd;
  logic [2:0] kc_last;
  logic [2:0] bc_last;
  logic [3:0] rounds;

  logic             advance;
  logic             done;
  rke_pkg::column_t prev;
  rke_pkg::column_t tap;
  rke_pkg::column_t sb_in;
  rke_pkg::column_t sb_out;
  rke_pkg::column_t mix;
  rke_pkg::column_t new_col;

  assign key_col[0] = job.key_a[31:0];
  assign key_col[1] = job.key_a[63:32];
  assign key_col[2] = job.key_b[31:0];
  assign key_col[3] = job.key_b[63:32];
  assign key_col[4] = job.key_c[31:0];
  assign key_col[5] = job.key_c[63:32];
  assign key_col[6] = job.key_d[31:0];
  assign key_col[7] = job.key_d[63:32];

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      rke_pkg::ENG_IDLE: begin
        if (job_valid) begin
          state_next = rke_pkg::ENG_RUN;
        end
      end
      rke_pkg::ENG_RUN: begin
        if (done) begin
          state_next = rke_pkg::ENG_IDLE;
        end
      end
      default: state_next = rke_pkg::ENG_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    job_take = 1'b0;
    advance  = 1'b0;
    busy     = 1'b0;
    unique case (state)
      rke_pkg::ENG_IDLE: begin
        job_take = job_valid;
      end
      rke_pkg::ENG_RUN: begin
        busy    = 1'b1;
        advance = !res_full;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
    res_push = advance && (pos == bc_last);
    done     = res_push && (rnd == rounds);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rke_pkg::ENG_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sreg[0] holds the newest column and sreg[kc_last] the column one key length back.
  // During the first pass the key simply rotates through, so its columns come out in order.
  always_comb begin
    prev  = sreg[0];
    tap   = sreg[kc_last];
    sb_in = (col_idx == 3'd0) ? {prev[7:0], prev[31:8]} : prev;
    sb_out = rke_pkg::sub_word(sb_in);
    if (first) begin
      mix = '0;
    end else if (col_idx == 3'd0) begin
      mix = sb_out ^ {24'd0, rke_pkg::RCON[rptr]};
    end else if ((kc_last >= 3'(rke_pkg::SBOX_SPLIT_COLUMNS)) && (col_idx == 3'd4)) begin
      mix = sb_out;
    end else begin
      mix = prev;
    end
    new_col = tap ^ mix;
  end

  always_comb begin
    for (int c = 0; c < rke_pkg::KEY_COL_SLOTS; c++) begin
      col_out[c] = (3'(c) == pos) ? new_col : rbuf[c];
    end
    res_item.round_index = rnd;
    res_item.key_a       = {col_out[1], col_out[0]};
    res_item.key_b       = {col_out[3], col_out[2]};
    res_item.key_c       = {col_out[5], col_out[4]};
    res_item.key_d       = {col_out[7], col_out[6]};
    res_item.last        = (rnd == rounds);
  end

  always_ff @(posedge clk) begin
    if (job_take) begin
      for (int i = 0; i < rke_pkg::KEY_COL_SLOTS; i++) begin
        sreg[i] <= key_col[3'(job.kc_last - 3'(i))];
        rbuf[i] <= '0;
      end
      kc_last <= job.kc_last;
      bc_last <= job.bc_last;
      rounds  <= job.rounds;
    end else if (advance) begin
      sreg[0] <= new_col;
      for (int i = 1; i < rke_pkg::KEY_COL_SLOTS; i++) begin
        sreg[i] <= sreg[i-1];
      end
      for (int c = 0; c < rke_pkg::KEY_COL_SLOTS; c++) begin
        if (res_push) begin
          rbuf[c] <= '0;
        end else if (3'(c) == pos) begin
          rbuf[c] <= new_col;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_idx <= 3'd0;
      first   <= 1'b1;
      rptr    <= 5'd1;
      pos     <= 3'd0;
      rnd     <= 4'd0;
    end else if (job_take) begin
      col_idx <= 3'd0;
      first   <= 1'b1;
      rptr    <= 5'd1;
      pos     <= 3'd0;
      rnd     <= 4'd0;
    end else if (advance) begin
      if (col_idx == kc_last) begin
        col_idx <= 3'd0;
        first   <= 1'b0;
      end else begin
        col_idx <= col_idx + 3'd1;
      end
      if (!first && (col_idx == 3'd0)) begin
        rptr <= rptr + 5'd1;
      end
      if (res_push) begin
        pos <= 3'd0;
        rnd <= rnd + 4'd1;
      end else begin
        pos <= pos + 3'd1;
      end
    end
  end

endmodule

FILE: src/rke_result_fifo.sv
// Two-entry queue of finished round keys between the engine and the result port.
// Depends on rke_pkg for the result type.
module rke_result_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  rke_pkg::result_t item,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output rke_pkg::result_t head
);

  rke_pkg::result_t entries [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             do_pop;

  assign full   = (count == 2'd2);
  assign empty  = (count == 2'd0);
  assign do_pop = pop && !empty;
  assign head   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(do_pop);
    end
  end

endmodule

FILE: src/rijndael_key_expansion_top.sv
// Rijndael key expansion: one cipher key in, round_count+1 round keys out, with
// round_count clamped into 1 to MAX_ROUNDS. The engine produces one key column per
// cycle through its single S-box word while the result queue has room, and takes
// the next key only when idle; the front queue holds up to two waiting keys.
// Synchronous active-high reset empties both queues and loads the configuration
// registers with 4 key columns, 4 block columns and 10 rounds.
module rijndael_key_expansion_top #(
  parameter int MAX_KEY_COLUMNS   = 8,
  parameter int MAX_BLOCK_COLUMNS = 8,
  parameter int MAX_ROUNDS        = 14
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [63:0] key_word_a,
  input  logic [63:0] key_word_b,
  input  logic [63:0] key_word_c,
  input  logic [63:0] key_word_d,
  input  logic        pop,
  output logic        empty,
  output logic [3:0]  round_index,
  output logic [63:0] round_key_a,
  output logic [63:0] round_key_b,
  output logic [63:0] round_key_c,
  output logic [63:0] round_key_d,
  output logic        last_round,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [3:0] key_columns;
  logic [3:0] block_columns;
  logic [3:0] round_count;
  logic       cfg_write;
  logic [1:0] reg_index;

  logic             job_valid;
  rke_pkg::job_t    job;
  logic             job_take;
  logic             res_full;
  logic             res_push;
  rke_pkg::result_t res_item;
  rke_pkg::result_t res_head;
  logic             busy;

  assign pready    = 1'b1;
  assign reg_index = paddr[3:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_columns   <= rke_pkg::KEY_COLUMNS_RESET;
      block_columns <= rke_pkg::BLOCK_COLUMNS_RESET;
      round_count   <= rke_pkg::ROUND_COUNT_RESET;
    end else if (cfg_write) begin
      unique case (reg_index)
        rke_pkg::REG_KEY_COLUMNS:   key_columns   <= pwdata[3:0];
        rke_pkg::REG_BLOCK_COLUMNS: block_columns <= pwdata[3:0];
        rke_pkg::REG_ROUND_COUNT:   round_count   <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      rke_pkg::REG_KEY_COLUMNS:   prdata = {28'd0, key_columns};
      rke_pkg::REG_BLOCK_COLUMNS: prdata = {28'd0, block_columns};
      rke_pkg::REG_ROUND_COUNT:   prdata = {28'd0, round_count};
      default:                    prdata = '0;
    endcase
  end

  rke_front #(
    .MAX_KEY_COLUMNS  (MAX_KEY_COLUMNS),
    .MAX_BLOCK_COLUMNS(MAX_BLOCK_COLUMNS),
    .MAX_ROUNDS       (MAX_ROUNDS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .key_word_a   (key_word_a),
    .key_word_b   (key_word_b),
    .key_word_c   (key_word_c),
    .key_word_d   (key_word_d),
    .key_columns  (key_columns),
    .block_columns(block_columns),
    .round_count  (round_count),
    .job_valid    (job_valid),
    .job          (job),
    .job_take     (job_take)
  );

  rke_engine u_engine (
    .clk      (clk),
    .rst      (rst),
    .job_valid(job_valid),
    .job      (job),
    .job_take (job_take),
    .res_full (res_full),
    .res_push (res_push),
    .res_item (res_item),
    .busy     (busy)
  );

  rke_result_fifo u_result_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (res_push),
    .item (res_item),
    .full (res_full),
    .pop  (pop),
    .empty(empty),
    .head (res_head)
  );

  assign round_index = res_head.round_index;
  assign round_key_a = res_head.key_a;
  assign round_key_b = res_head.key_b;
  assign round_key_c = res_head.key_c;
  assign round_key_d = res_head.key_d;
  assign last_round  = res_head.last;

  // The engine never writes a round key into a full result queue.
  assert property (@(posedge clk) disable iff (rst) res_push |-> !res_full)
    else $error("round key written into a full result queue");

  // A job is taken only when the front queue has one waiting.
  assert property (@(posedge clk) disable iff (rst) job_take |-> job_valid)
    else $error("engine took a job from an empty front queue");

  // After the final round key of an expansion the engine is idle.
  assert property (@(posedge clk) disable iff (rst) (res_push && res_item.last) |=> !busy)
    else $error("engine still busy after the last round key");

endmodule
